>>> rtl/core/inplace_vertical_row_stretch_assert.svh
// assertion macros shared by the frame store blocks
`ifndef INPLACE_VERTICAL_ROW_STRETCH_ASSERT_SVH
`define INPLACE_VERTICAL_ROW_STRETCH_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define IVRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition that must never be true outside reset
`define IVRS_ASSERT_NEVER(lbl, cond, msg) \
  `IVRS_ASSERT(lbl, !(cond), msg)

`endif

>>> rtl/core/ivrs_pkg.sv
package ivrs_pkg;

  // payload field widths
  localparam int unsigned DataW      = 16;
  localparam int unsigned RowW       = 8;
  localparam int unsigned ColW       = 9;
  localparam int unsigned FuncW      = 2;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned CfgW       = 8;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned InTdataW   = 40;
  localparam int unsigned OutTdataW  = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TOP_ROW       = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_CONTENT_LINES = 1'b1;

  // reset values of the configuration registers
  localparam logic [CfgW-1:0] TOP_ROW_RST       = 8'd0;
  localparam logic [CfgW-1:0] CONTENT_LINES_RST = 8'd240;

  // operation codes carried in the input tuser
  typedef enum logic [FuncW-1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_EXPAND = 2'd2
  } func_e;

  // result codes carried in the output tuser
  typedef enum logic [StatusW-1:0] {
    STATUS_WRITE_DONE  = 2'd0,
    STATUS_READ_VALID  = 2'd1,
    STATUS_EXPAND_DONE = 2'd2,
    STATUS_EXPAND_SKIP = 2'd3
  } status_e;

  // expand sequencer states
  typedef enum logic [2:0] {
    SEQ_IDLE = 3'd0,
    SEQ_SCAN = 3'd1,
    SEQ_ROW  = 3'd2,
    SEQ_COPY = 3'd3,
    SEQ_ADV  = 3'd4
  } seq_state_e;

  // sequencer status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
  } seq_stat_t;

endpackage

>>> rtl/core/ivrs_frame_mem.sv
module ivrs_frame_mem
  import ivrs_pkg::*;
#(
  parameter int unsigned DEPTH = 76800,
  parameter int unsigned AW    = 17
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [DEPTH];
  logic [DataW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds its data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/ivrs_expand_seq.sv
`include "inplace_vertical_row_stretch_assert.svh"

module ivrs_expand_seq
  import ivrs_pkg::*;
#(
  parameter int unsigned FRAME_HEIGHT = 240,
  parameter int unsigned FRAME_WIDTH  = 320,
  parameter int unsigned AW           = 17
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [CfgW-1:0] top_row_i,
  input  logic [CfgW-1:0] content_lines_i,
  output seq_stat_t       stat_o,
  output logic            rd_en_o,
  output logic [AW-1:0]   rd_addr_o,
  output logic            wr_en_o,
  output logic [AW-1:0]   wr_addr_o
);

  localparam int unsigned YW = $clog2(FRAME_HEIGHT);
  localparam int unsigned RW = ((YW > CfgW) ? YW : CfgW) + 2;
  localparam int unsigned XW = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;

  seq_state_e      state_q, state_d;
  logic            bottom_q, bottom_d;
  logic [YW-1:0]   y_q, y_d;
  logic [CfgW-1:0] q_q, q_d;
  logic [YW-1:0]   acc_q, acc_d;
  logic [YW-1:0]   fixed_q, fixed_d;
  logic [XW-1:0]   x_q, x_d;
  logic [AW-1:0]   src_base_q, src_base_d;
  logic [AW-1:0]   dst_base_q, dst_base_d;
  logic            wr_en_q, wr_en_d;
  logic [AW-1:0]   wr_addr_q, wr_addr_d;

  logic [RW-1:0]   src_row;
  logic [RW-1:0]   cur_row;
  logic [RW-1:0]   up_sum;
  logic [RW-1:0]   height_ext;
  logic [RW-1:0]   lines_ext;

  // source row of the current line and the running quotient steps
  assign height_ext = RW'(FRAME_HEIGHT);
  assign lines_ext  = RW'(content_lines_i);
  assign src_row    = RW'(top_row_i) + RW'(q_q);
  assign cur_row    = RW'(y_q);
  assign up_sum     = RW'(acc_q) + lines_ext;

  // state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SEQ_IDLE;
      bottom_q <= 1'b0;
      wr_en_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      bottom_q <= bottom_d;
      wr_en_q  <= wr_en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q        <= y_d;
    q_q        <= q_d;
    acc_q      <= acc_d;
    fixed_q    <= fixed_d;
    x_q        <= x_d;
    src_base_q <= src_base_d;
    dst_base_q <= dst_base_d;
    wr_addr_q  <= wr_addr_d;
  end

  // next state, row stepping and memory requests
  always_comb begin
    state_d    = state_q;
    bottom_d   = bottom_q;
    y_d        = y_q;
    q_d        = q_q;
    acc_d      = acc_q;
    fixed_d    = fixed_q;
    x_d        = x_q;
    src_base_d = src_base_q;
    dst_base_d = dst_base_q;
    wr_en_d    = 1'b0;
    wr_addr_d  = wr_addr_q;
    rd_en_o    = 1'b0;
    rd_addr_o  = src_base_q + AW'(x_q);
    stat_o     = '{busy: (state_q != SEQ_IDLE), done: 1'b0};

    unique case (state_q)
      SEQ_IDLE: begin
        if (start_i) begin
          y_d      = '0;
          q_d      = '0;
          acc_d    = '0;
          bottom_d = 1'b0;
          state_d  = SEQ_SCAN;
        end
      end

      // search the first row whose source is at or above it
      SEQ_SCAN: begin
        if (src_row <= cur_row) begin
          fixed_d = y_q;
          y_d     = '0;
          q_d     = '0;
          acc_d   = '0;
          state_d = SEQ_ROW;
        end else begin
          y_d = y_q + YW'(1);
          if (up_sum >= height_ext) begin
            acc_d = YW'(up_sum - height_ext);
            q_d   = q_q + CfgW'(1);
          end else begin
            acc_d = YW'(up_sum);
          end
        end
      end

      // pick the next row to copy or switch to the bottom-up pass
      SEQ_ROW: begin
        if (!bottom_q && (y_q == fixed_q)) begin
          bottom_d = 1'b1;
          y_d      = YW'(FRAME_HEIGHT - 1);
          q_d      = content_lines_i - CfgW'(1);
          acc_d    = YW'(height_ext - lines_ext);
        end else if (bottom_q && (src_row == cur_row)) begin
          state_d = SEQ_ADV;
        end else begin
          src_base_d = AW'(src_row) * AW'(FRAME_WIDTH);
          dst_base_d = AW'(y_q) * AW'(FRAME_WIDTH);
          x_d        = '0;
          state_d    = SEQ_COPY;
        end
      end

      // one pixel read per cycle, each written back from the registered read data
      SEQ_COPY: begin
        rd_en_o   = 1'b1;
        wr_en_d   = 1'b1;
        wr_addr_d = dst_base_q + AW'(x_q);
        x_d       = x_q + XW'(1);
        if (x_q == XW'(FRAME_WIDTH - 1)) begin
          state_d = SEQ_ADV;
        end
      end

      // step to the next row in the current direction
      SEQ_ADV: begin
        if (!bottom_q) begin
          y_d     = y_q + YW'(1);
          state_d = SEQ_ROW;
          if (up_sum >= height_ext) begin
            acc_d = YW'(up_sum - height_ext);
            q_d   = q_q + CfgW'(1);
          end else begin
            acc_d = YW'(up_sum);
          end
        end else if (y_q == fixed_q) begin
          stat_o.done = 1'b1;
          state_d     = SEQ_IDLE;
        end else begin
          y_d     = y_q - YW'(1);
          state_d = SEQ_ROW;
          if (RW'(acc_q) < lines_ext) begin
            acc_d = YW'(RW'(acc_q) + height_ext - lines_ext);
            q_d   = q_q - CfgW'(1);
          end else begin
            acc_d = YW'(RW'(acc_q) - lines_ext);
          end
        end
      end

      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  assign wr_en_o   = wr_en_q;
  assign wr_addr_o = wr_addr_q;

  // checks on the copy pipeline and on start
  `IVRS_ASSERT(a_wr_after_rd, wr_en_q |-> $past(rd_en_o), "write without preceding read")
  `IVRS_ASSERT_NEVER(a_no_same_entry, rd_en_o && wr_en_q && (rd_addr_o == wr_addr_q),
                     "read and write of one entry in one cycle")
  `IVRS_ASSERT(a_start_idle, start_i |-> (state_q == SEQ_IDLE), "start while busy")

endmodule

>>> rtl/core/inplace_vertical_row_stretch.sv
// Pixel write and read: one transaction per cycle unless held off, through the result
// stage and the output register. Expand: scans for the fixed row, then copies each row
// pixel by pixel and steps over rows left in place, bound by the one read and one write
// port of the frame store; input is held off until the expand result is loaded.
// Reset clears control state and sets top_row to 0 and content_lines to 240;
// the frame store is not cleared and holds undefined data until written.
`include "inplace_vertical_row_stretch_assert.svh"

module inplace_vertical_row_stretch
  import ivrs_pkg::*;
#(
  parameter int unsigned FRAME_HEIGHT = 240,
  parameter int unsigned FRAME_WIDTH  = 320
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // row[7:0], column[16:8], pixel_in[32:17]
  input  logic [FuncW-1:0]     s_axis_tuser,   // func[1:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,   // pixel_out[15:0]
  output logic [StatusW-1:0]   m_axis_tuser,   // status[1:0]
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_wdata_i
);

  localparam int unsigned DEPTH = FRAME_HEIGHT * FRAME_WIDTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned YW    = $clog2(FRAME_HEIGHT);
  localparam int unsigned RW    = ((YW > CfgW) ? YW : CfgW) + 2;
  localparam int unsigned XCW   = (($clog2(FRAME_WIDTH) > ColW) ? $clog2(FRAME_WIDTH) : ColW) + 2;

  logic [CfgW-1:0]  top_row_q;
  logic [CfgW-1:0]  content_lines_q;

  logic [RowW-1:0]  in_row;
  logic [ColW-1:0]  in_col;
  logic [DataW-1:0] in_pixel;
  func_e            in_func;
  logic             in_xact;
  logic             in_range;
  logic             expand_skip;
  logic [AW-1:0]    pix_addr;

  logic             pix_we;
  logic             pix_re;

  logic             exp_pend_q, exp_pend_d;
  logic             seq_start;
  seq_stat_t        seq_stat;
  logic             seq_rd_en;
  logic [AW-1:0]    seq_rd_addr;
  logic             seq_wr_en;
  logic [AW-1:0]    seq_wr_addr;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [DataW-1:0] mem_rdata;

  logic             s1_valid_q, s1_valid_d;
  status_e          s1_status_q, s1_status_d;
  logic             s1_rd_q, s1_rd_d;
  logic             s1_load;
  logic             s1_adv;

  logic             out_valid_q;
  status_e          out_status_q;
  logic [DataW-1:0] out_pixel_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_row_q       <= TOP_ROW_RST;
      content_lines_q <= CONTENT_LINES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TOP_ROW:       top_row_q       <= cfg_wdata_i;
        CFG_CONTENT_LINES: content_lines_q <= cfg_wdata_i;
        default:           top_row_q       <= top_row_q;
      endcase
    end
  end

  // input field decode
  assign in_row   = s_axis_tdata[RowW-1:0];
  assign in_col   = s_axis_tdata[RowW+ColW-1:RowW];
  assign in_pixel = s_axis_tdata[RowW+ColW+DataW-1:RowW+ColW];
  assign in_func  = func_e'(s_axis_tuser);
  assign in_range = (RW'(in_row) < RW'(FRAME_HEIGHT)) && (XCW'(in_col) < XCW'(FRAME_WIDTH));
  assign pix_addr = AW'(in_row) * AW'(FRAME_WIDTH) + AW'(in_col);

  assign expand_skip = (content_lines_q == '0)
                    || (RW'(content_lines_q) >= RW'(FRAME_HEIGHT))
                    || ((RW'(top_row_q) + RW'(content_lines_q)) > RW'(FRAME_HEIGHT));

  // intake: one transaction per cycle while the result stage can move and no expand is pending or busy
  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !seq_stat.busy && !exp_pend_q && (!s1_valid_q || s1_adv);
  assign in_xact       = s_axis_tvalid && s_axis_tready;

  // operation dispatch and result stage load
  always_comb begin
    pix_we      = 1'b0;
    pix_re      = 1'b0;
    exp_pend_d  = exp_pend_q && !seq_start;
    s1_load     = 1'b0;
    s1_status_d = s1_status_q;
    s1_rd_d     = s1_rd_q;

    if (in_xact) begin
      unique case (in_func)
        FUNC_WRITE: begin
          pix_we      = in_range;
          s1_load     = 1'b1;
          s1_status_d = STATUS_WRITE_DONE;
          s1_rd_d     = 1'b0;
        end
        FUNC_READ: begin
          pix_re      = in_range;
          s1_load     = 1'b1;
          s1_status_d = STATUS_READ_VALID;
          s1_rd_d     = in_range;
        end
        FUNC_EXPAND: begin
          if (expand_skip) begin
            s1_load     = 1'b1;
            s1_status_d = STATUS_EXPAND_SKIP;
            s1_rd_d     = 1'b0;
          end else begin
            exp_pend_d = 1'b1;
          end
        end
        default: begin
          s1_load     = 1'b1;
          s1_status_d = STATUS_WRITE_DONE;
          s1_rd_d     = 1'b0;
        end
      endcase
    end else if (seq_stat.done) begin
      s1_load     = 1'b1;
      s1_status_d = STATUS_EXPAND_DONE;
      s1_rd_d     = 1'b0;
    end

    priority if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  // the sequencer starts once no result is left in the result stage
  assign seq_start = exp_pend_q && !s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_pend_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      exp_pend_q <= exp_pend_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_status_q <= s1_status_d;
    s1_rd_q     <= s1_rd_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_status_q <= s1_status_q;
      out_pixel_q  <= s1_rd_q ? mem_rdata : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pixel_q;
  assign m_axis_tuser  = out_status_q;

  // frame store port select: the sequencer owns it while busy
  assign mem_we    = seq_stat.busy ? seq_wr_en : pix_we;
  assign mem_waddr = seq_stat.busy ? seq_wr_addr : pix_addr;
  assign mem_wdata = seq_stat.busy ? mem_rdata : in_pixel;
  assign mem_re    = seq_stat.busy ? seq_rd_en : pix_re;
  assign mem_raddr = seq_stat.busy ? seq_rd_addr : pix_addr;

  ivrs_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ivrs_expand_seq #(
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .FRAME_WIDTH  (FRAME_WIDTH),
    .AW           (AW)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (seq_start),
    .top_row_i       (top_row_q),
    .content_lines_i (content_lines_q),
    .stat_o          (seq_stat),
    .rd_en_o         (seq_rd_en),
    .rd_addr_o       (seq_rd_addr),
    .wr_en_o         (seq_wr_en),
    .wr_addr_o       (seq_wr_addr)
  );

  // checks on intake and result stage sharing
  `IVRS_ASSERT_NEVER(a_no_xact_busy, in_xact && seq_stat.busy, "transaction accepted during expand")
  `IVRS_ASSERT(a_done_stage_free, seq_stat.done |-> !s1_valid_q, "expand done with stage full")
  `IVRS_ASSERT(a_pend_not_busy, exp_pend_q |-> !seq_stat.busy, "pending expand while busy")

endmodule
